@@ rtl/mpfm_pkg.sv @@
// Package for the multi-period frequency meter: field widths, register map,
// reset values, item codes and the structs passed between the meter modules.
// No dependencies.
`timescale 1ns / 1ps

package mpfm_pkg;

  // Field and counter widths.
  localparam int TICK_BITS = 24;
  localparam int PCNT_W    = 8;
  localparam int TOUT_W    = 24;
  localparam int HZ_W      = 27;
  localparam int FREQ_W    = 27;

  // Numerator of the division is clock_hz times a period count of up to 256.
  localparam int NUM_W  = HZ_W + PCNT_W + 1;
  localparam int STEP_W = $clog2(NUM_W);

  localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};
  localparam logic [FREQ_W-1:0]    FREQ_MAX = {FREQ_W{1'b1}};

  // Configuration port.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] REG_PERIOD_COUNT  = 2'd0;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd1;
  localparam logic [1:0] REG_CLOCK_HZ      = 2'd2;

  localparam logic [PCNT_W-1:0] PCNT_RESET = PCNT_W'(60);
  localparam logic [TOUT_W-1:0] TOUT_RESET = TOUT_W'(24'hFFFFFF);
  localparam logic [HZ_W-1:0]   HZ_RESET   = HZ_W'(32000000);

  // Input word opcodes.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef struct packed {
    logic [PCNT_W-1:0] period_count;
    logic [TOUT_W-1:0] timeout_ticks;
    logic [HZ_W-1:0]   clock_hz;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic [TICK_BITS-1:0] period_ticks;
    logic [FREQ_W-1:0]    frequency_hz;
  } div_res_t;

endpackage

@@ rtl/mpfm_in_if.sv @@
// Input channel of the frequency meter: one word is a tick or a start.
// No dependencies.
`timescale 1ns / 1ps

interface mpfm_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic pin_level;

  modport source (output valid, output opcode, output pin_level, input ready);
  modport sink (input valid, input opcode, input pin_level, output ready);
endinterface

@@ rtl/mpfm_out_if.sv @@
// Result channel of the frequency meter: tick count, frequency and timeout flag.
// Depends on mpfm_pkg.
`timescale 1ns / 1ps

interface mpfm_out_if;
  logic                             valid;
  logic                             ready;
  logic [mpfm_pkg::TICK_BITS-1:0]   period_ticks;
  logic [mpfm_pkg::FREQ_W-1:0]      frequency_hz;
  logic                             timed_out;

  modport source (output valid, output period_ticks, output frequency_hz,
                  output timed_out, input ready);
  modport sink (input valid, input period_ticks, input frequency_hz,
                input timed_out, output ready);
endinterface

@@ rtl/mpfm_cfg.sv @@
// APB-style configuration registers of the frequency meter.
// Depends on mpfm_pkg.
`timescale 1ns / 1ps

module mpfm_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mpfm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mpfm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mpfm_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output mpfm_pkg::cfg_t                  cfg_o
);

  mpfm_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_count  <= mpfm_pkg::PCNT_RESET;
      cfg_q.timeout_ticks <= mpfm_pkg::TOUT_RESET;
      cfg_q.clock_hz      <= mpfm_pkg::HZ_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        mpfm_pkg::REG_PERIOD_COUNT: begin
          cfg_q.period_count <= pwdata[mpfm_pkg::PCNT_W-1:0];
        end
        mpfm_pkg::REG_TIMEOUT_TICKS: begin
          cfg_q.timeout_ticks <= pwdata[mpfm_pkg::TOUT_W-1:0];
        end
        mpfm_pkg::REG_CLOCK_HZ: begin
          cfg_q.clock_hz <= pwdata[mpfm_pkg::HZ_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mpfm_pkg::REG_PERIOD_COUNT: begin
        prdata = mpfm_pkg::APB_DATA_W'(cfg_q.period_count);
      end
      mpfm_pkg::REG_TIMEOUT_TICKS: begin
        prdata = mpfm_pkg::APB_DATA_W'(cfg_q.timeout_ticks);
      end
      mpfm_pkg::REG_CLOCK_HZ: begin
        prdata = mpfm_pkg::APB_DATA_W'(cfg_q.clock_hz);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

@@ rtl/mpfm_div.sv @@
// Bit-serial restoring divider: clock_hz times the period count over the tick
// count, one quotient bit per cycle, saturated to the frequency width.
// Depends on mpfm_pkg.
`timescale 1ns / 1ps

module mpfm_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [mpfm_pkg::HZ_W-1:0]           clock_hz_i,
  input  logic [mpfm_pkg::PCNT_W-1:0]         periods_i,
  input  logic [mpfm_pkg::TICK_BITS-1:0]      den_i,
  input  logic                                ack_i,
  output mpfm_pkg::div_stat_t                 stat_o,
  output mpfm_pkg::div_res_t                  res_o
);

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

  div_state_e                          state_q;
  logic [mpfm_pkg::STEP_W-1:0]         cnt_q;
  logic [mpfm_pkg::TICK_BITS-1:0]      den_q;
  logic [mpfm_pkg::TICK_BITS-1:0]      rem_q;
  logic [mpfm_pkg::NUM_W-1:0]          quo_q;

  logic [mpfm_pkg::PCNT_W:0]           n_periods;
  logic [mpfm_pkg::NUM_W-1:0]          num;
  logic [mpfm_pkg::TICK_BITS:0]        shifted;
  logic [mpfm_pkg::TICK_BITS+1:0]      diff;
  logic                                ge;

  // A period count of zero wraps, so 256 periods are timed.
  assign n_periods = {(periods_i == '0), periods_i};
  assign num       = mpfm_pkg::NUM_W'(clock_hz_i * n_periods);

  // The numerator shifts out of the top of quo_q while quotient bits shift in.
  assign shifted = {rem_q, quo_q[mpfm_pkg::NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};
  assign ge      = !diff[mpfm_pkg::TICK_BITS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
      den_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
    end else begin
      case (state_q)
        DIV_IDLE: begin
          if (start_i) begin
            state_q <= DIV_RUN;
            cnt_q   <= mpfm_pkg::STEP_W'(mpfm_pkg::NUM_W - 1);
            den_q   <= den_i;
            rem_q   <= '0;
            quo_q   <= num;
          end
        end
        DIV_RUN: begin
          rem_q <= ge ? diff[mpfm_pkg::TICK_BITS-1:0] : shifted[mpfm_pkg::TICK_BITS-1:0];
          quo_q <= {quo_q[mpfm_pkg::NUM_W-2:0], ge};
          if (cnt_q == '0) begin
            state_q <= DIV_DONE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        DIV_DONE: begin
          if (ack_i) begin
            state_q <= DIV_IDLE;
          end
        end
        default: begin
          state_q <= DIV_IDLE;
        end
      endcase
    end
  end

  assign stat_o.busy = (state_q == DIV_RUN);
  assign stat_o.done = (state_q == DIV_DONE);

  assign res_o.period_ticks = den_q;
  assign res_o.frequency_hz =
      (|quo_q[mpfm_pkg::NUM_W-1:mpfm_pkg::FREQ_W]) ? mpfm_pkg::FREQ_MAX
                                                   : quo_q[mpfm_pkg::FREQ_W-1:0];

endmodule

@@ rtl/multi_period_frequency_meter_unit.sv @@
// Multi-period reciprocal frequency meter: start and tick words go in, one result word per
// finished or timed-out measurement comes out. Start and tick words are taken one per cycle
// while no result is pending. The word that completes the last period starts a bit-serial
// divide; no word is taken until its result is in the output register. A timeout result
// goes via the pending timeout flag to the output register. Reset (rst_ni low, asynchronous)
// restores the register defaults, idles the meter and empties the output register.
`timescale 1ns / 1ps

module multi_period_frequency_meter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mpfm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mpfm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mpfm_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  mpfm_in_if.sink                         in_i,
  mpfm_out_if.source                      res_o
);

  // Measurement phases. The two counting phases alternate once per input period.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT_LOW,
    PH_WAIT_HIGH,
    PH_CNT_LOW,
    PH_CNT_HIGH
  } phase_e;

  mpfm_pkg::cfg_t      cfg;
  mpfm_pkg::div_stat_t div_st;
  mpfm_pkg::div_res_t  div_res;

  phase_e                          phase_q, phase_d;
  logic [mpfm_pkg::TICK_BITS-1:0]  ticks_q, ticks_d;
  logic [mpfm_pkg::PCNT_W-1:0]     periods_q, periods_d;
  logic                            tout_pend_q, tout_set;
  logic                            out_valid_q;
  logic [mpfm_pkg::TICK_BITS-1:0]  out_ticks_q;
  logic [mpfm_pkg::FREQ_W-1:0]     out_freq_q;
  logic                            out_tout_q;

  logic                            accept;
  logic                            div_start;
  logic [mpfm_pkg::TICK_BITS-1:0]  ticks_inc;
  logic [mpfm_pkg::PCNT_W-1:0]     periods_inc;
  logic                            lim_hit;
  logic                            out_free;
  logic                            take_div;
  logic                            take_tout;

  mpfm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mpfm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .clock_hz_i (cfg.clock_hz),
    .periods_i  (cfg.period_count),
    .den_i      (ticks_inc),
    .ack_i      (take_div),
    .stat_o     (div_st),
    .res_o      (div_res)
  );

  // Words are taken whenever no result is being produced. A finished word may still sit in
  // the output register; new results wait in the divider or in the timeout flag until it drains.
  assign in_i.ready = !div_st.busy && !div_st.done && !tout_pend_q;
  assign accept     = in_i.valid && in_i.ready;

  // The phase tick counter saturates at its maximum instead of wrapping.
  assign ticks_inc   = (ticks_q == mpfm_pkg::TICK_MAX) ? ticks_q : ticks_q + 1'b1;
  assign periods_inc = periods_q + 1'b1;
  assign lim_hit     = (ticks_inc >= cfg.timeout_ticks);

  // Next measurement state for one accepted word. Any result returns the meter to idle.
  always_comb begin
    phase_d   = phase_q;
    ticks_d   = ticks_q;
    periods_d = periods_q;
    tout_set  = 1'b0;
    div_start = 1'b0;
    if (accept) begin
      if (in_i.opcode == mpfm_pkg::OP_START) begin
        phase_d   = PH_WAIT_LOW;
        ticks_d   = '0;
        periods_d = '0;
      end else begin
        case (phase_q)
          PH_WAIT_LOW: begin
            if (!in_i.pin_level) begin
              phase_d = PH_WAIT_HIGH;
              ticks_d = '0;
            end else begin
              ticks_d  = ticks_inc;
              tout_set = lim_hit;
            end
          end
          PH_WAIT_HIGH: begin
            if (in_i.pin_level) begin
              phase_d   = PH_CNT_LOW;
              ticks_d   = '0;
              periods_d = '0;
            end else begin
              ticks_d  = ticks_inc;
              tout_set = lim_hit;
            end
          end
          PH_CNT_LOW: begin
            ticks_d = ticks_inc;
            if (!in_i.pin_level) begin
              phase_d = PH_CNT_HIGH;
            end else begin
              tout_set = lim_hit;
            end
          end
          PH_CNT_HIGH: begin
            ticks_d = ticks_inc;
            if (in_i.pin_level) begin
              periods_d = periods_inc;
              // Completing the last period wins over a timeout on the same tick.
              if (periods_inc == cfg.period_count) begin
                div_start = 1'b1;
              end else begin
                phase_d  = PH_CNT_LOW;
                tout_set = lim_hit;
              end
            end else begin
              tout_set = lim_hit;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
        if (tout_set || div_start) begin
          phase_d   = PH_IDLE;
          ticks_d   = '0;
          periods_d = '0;
        end
      end
    end
  end

  // Only one result source can be pending at a time.
  assign out_free  = !out_valid_q || res_o.ready;
  assign take_div  = div_st.done && out_free;
  assign take_tout = tout_pend_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      ticks_q     <= '0;
      periods_q   <= '0;
      tout_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_ticks_q <= '0;
      out_freq_q  <= '0;
      out_tout_q  <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      ticks_q   <= ticks_d;
      periods_q <= periods_d;
      if (tout_set) begin
        tout_pend_q <= 1'b1;
      end else if (take_tout) begin
        tout_pend_q <= 1'b0;
      end
      if (take_div) begin
        out_valid_q <= 1'b1;
        out_ticks_q <= div_res.period_ticks;
        out_freq_q  <= div_res.frequency_hz;
        out_tout_q  <= 1'b0;
      end else if (take_tout) begin
        out_valid_q <= 1'b1;
        out_ticks_q <= '0;
        out_freq_q  <= '0;
        out_tout_q  <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.period_ticks = out_ticks_q;
  assign res_o.frequency_hz = out_freq_q;
  assign res_o.timed_out    = out_tout_q;

  // The meter has already gone idle whenever the divider is running.
  a_idle_while_dividing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) div_st.busy |-> phase_q == PH_IDLE
  ) else $error("meter left idle while the divider runs");

  // A timeout result and a division result never wait at the same time.
  a_single_pending : assert property (
    @(posedge clk_i) disable iff (!rst_ni) !(div_st.done && tout_pend_q)
  ) else $error("two results pending at once");

  // The idle phase always carries cleared counters.
  a_idle_clear : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> (ticks_q == '0 && periods_q == '0)
  ) else $error("idle phase with stale counters");

  // A timed-out result reports zeros.
  a_tout_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.timed_out) |-> (res_o.period_ticks == '0 && res_o.frequency_hz == '0)
  ) else $error("timed-out result with nonzero fields");

  // A division launches only after a tick word was taken in a counting phase.
  a_div_launch : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(div_st.busy) |-> $past(accept) && $past(phase_q) == PH_CNT_HIGH
  ) else $error("divider started without a completing tick");

endmodule
